[rtl/lbvs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lbvs_pkg;

    // Bone store geometry.
    localparam int MAX_BONES      = 128;
    localparam int WORDS_PER_BONE = 12;
    localparam int MEM_DEPTH      = MAX_BONES * WORDS_PER_BONE;
    localparam int ADDR_W         = $clog2(MEM_DEPTH);
    localparam int TRANS_BASE     = 9;

    // Fixed-point format and the width of a three-term dot product plus translation.
    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 66 - FRAC_BITS;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Function codes of an input item.
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_VERTEX = 2'd1,
        FUNC_WEIGHT = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Commands that reach the back.
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_VERTEX,
        CMD_WEIGHT
    } cmd_t;

    // One classified item in the queue.
    typedef struct packed {
        cmd_t               cmd;
        logic               ok;
        logic               last;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] wt;
    } item_t;

    // Back sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_WMUL,
        ST_WACC,
        ST_NORM,
        ST_DONE
    } state_t;

    // Saturate a signed value to a 32-bit word.
    function automatic logic signed [31:0] sat_word(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/linear_blend_vertex_skinner.sv]
// The back works on one item at a time, its pace set by the single shared 32x32 multiplier
// and the bone store with its one write and one read port, each rotation product taking a
// read, a multiply and an add step.
// A two-entry queue lets input items be taken while the back works.
// Reset is asynchronous and active low: it clears control, accumulator and normal, and sets bone_count to 128.
`timescale 1ns / 1ps
`default_nettype none

module linear_blend_vertex_skinner (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic [7:0]         bone,
    input  wire logic [3:0]         elem,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [31:0] blend,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [31:0]      norm_x,
    output logic signed [31:0]      norm_y,
    output logic signed [31:0]      norm_z,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata
);

    logic [7:0]      bone_count_reg;
    lbvs_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    // Bone count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bone_count_reg <= 8'd128;
        else if (cfg_we)
            bone_count_reg <= cfg_wdata;
    end

    lbvs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .bone       (bone),
        .elem       (elem),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .vec_z      (vec_z),
        .blend      (blend),
        .last       (last),
        .bone_count (bone_count_reg),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop)
    );

    lbvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z)
    );

endmodule

`default_nettype wire

[rtl/lbvs_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbvs_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           func,
    input  wire logic [7:0]           bone,
    input  wire logic [3:0]           elem,
    input  wire logic signed [31:0]   vec_x,
    input  wire logic signed [31:0]   vec_y,
    input  wire logic signed [31:0]   vec_z,
    input  wire logic signed [31:0]   blend,
    input  wire logic                 last,
    input  wire logic [7:0]           bone_count,
    output lbvs_pkg::item_t           q_item,
    output logic                      q_valid,
    input  wire logic                 q_pop
);

    logic                       in_range;
    logic                       bone_ok;
    logic                       keep;
    logic                       push;
    logic [12:0]                addr_wide;
    lbvs_pkg::item_t            new_item;
    lbvs_pkg::item_t            q_mem [lbvs_pkg::QUEUE_DEPTH];
    logic [lbvs_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [lbvs_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [lbvs_pkg::PTR_W:0]   count_reg;
    logic [lbvs_pkg::PTR_W:0]   count_next;

    // Classify the incoming item.
    always_comb
    begin
        in_range  = {1'b0, bone} < 9'(lbvs_pkg::MAX_BONES);
        bone_ok   = in_range && (bone < bone_count);
        addr_wide = {5'b0, bone} * 13'(lbvs_pkg::WORDS_PER_BONE);
        keep      = 1'b0;
        new_item.cmd = lbvs_pkg::CMD_LOAD;
        unique case (lbvs_pkg::func_t'(func))
            lbvs_pkg::FUNC_LOAD:
            begin
                keep         = in_range && (elem < 4'(lbvs_pkg::WORDS_PER_BONE));
                addr_wide    = addr_wide + {9'b0, elem};
                new_item.cmd = lbvs_pkg::CMD_LOAD;
            end
            lbvs_pkg::FUNC_VERTEX:
            begin
                keep         = 1'b1;
                new_item.cmd = lbvs_pkg::CMD_VERTEX;
            end
            lbvs_pkg::FUNC_WEIGHT:
            begin
                keep         = 1'b1;
                new_item.cmd = lbvs_pkg::CMD_WEIGHT;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        new_item.ok   = bone_ok;
        new_item.last = last;
        new_item.addr = addr_wide[lbvs_pkg::ADDR_W-1:0];
        new_item.vx   = vec_x;
        new_item.vy   = vec_y;
        new_item.vz   = vec_z;
        new_item.wt   = blend;
    end

    // Queue handshake; items with no effect are taken and dropped.
    assign in_ready = count_reg != (lbvs_pkg::PTR_W + 1)'(lbvs_pkg::QUEUE_DEPTH);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = count_reg != '0;
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_item;
    end

endmodule

`default_nettype wire

[rtl/lbvs_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbvs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lbvs_pkg::item_t     q_item,
    input  wire logic                q_valid,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       pos_x,
    output logic signed [31:0]       pos_y,
    output logic signed [31:0]       pos_z,
    output logic signed [31:0]       norm_x,
    output logic signed [31:0]       norm_y,
    output logic signed [31:0]       norm_z
);

    lbvs_pkg::state_t                 state_reg;
    lbvs_pkg::state_t                 state_next;
    lbvs_pkg::item_t                  cur_reg;
    logic [1:0]                       comp_reg;
    logic [1:0]                       term_reg;
    logic signed [lbvs_pkg::SUM_W-1:0] sum_reg;
    logic signed [63:0]               prod_reg;
    logic signed [31:0]               rdata_reg;
    logic signed [31:0]               acc_reg [3];
    logic signed [31:0]               hn_reg [3];
    logic signed [31:0]               pos_reg [3];
    logic signed [31:0]               norm_reg [3];
    logic                             out_valid_reg;
    logic signed [31:0]               bone_mem [lbvs_pkg::MEM_DEPTH];

    logic                             mem_we;
    logic                             out_load;
    logic [3:0]                       word_off;
    logic [lbvs_pkg::ADDR_W-1:0]      rd_addr;
    logic signed [31:0]               opnd;
    logic signed [63:0]               prod_sh;
    logic signed [31:0]               sum_sat;
    logic signed [31:0]               w_term;
    logic signed [31:0]               acc_sum;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbvs_pkg::ST_IDLE:
            begin
                if (q_valid && q_item.cmd != lbvs_pkg::CMD_LOAD)
                begin
                    if (q_item.ok)
                        state_next = lbvs_pkg::ST_RD;
                    else if (q_item.last)
                        state_next = lbvs_pkg::ST_DONE;
                end
            end
            lbvs_pkg::ST_RD:
                state_next = (term_reg == 2'd3) ? lbvs_pkg::ST_ACC : lbvs_pkg::ST_MUL;
            lbvs_pkg::ST_MUL:
                state_next = lbvs_pkg::ST_ACC;
            lbvs_pkg::ST_ACC:
            begin
                if (term_reg == 2'd3)
                    state_next = lbvs_pkg::ST_WMUL;
                else if (term_reg == 2'd2 && cur_reg.cmd == lbvs_pkg::CMD_VERTEX)
                    state_next = lbvs_pkg::ST_NORM;
                else
                    state_next = lbvs_pkg::ST_RD;
            end
            lbvs_pkg::ST_WMUL:
                state_next = lbvs_pkg::ST_WACC;
            lbvs_pkg::ST_WACC, lbvs_pkg::ST_NORM:
            begin
                if (comp_reg != 2'd2)
                    state_next = lbvs_pkg::ST_RD;
                else if (cur_reg.last)
                    state_next = lbvs_pkg::ST_DONE;
                else
                    state_next = lbvs_pkg::ST_IDLE;
            end
            lbvs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = lbvs_pkg::ST_IDLE;
            end
            default:
                state_next = lbvs_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            lbvs_pkg::ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && q_item.cmd == lbvs_pkg::CMD_LOAD;
            end
            lbvs_pkg::ST_DONE:
                out_load = !out_valid_reg || out_ready;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Bone word address and operand for the current term, plus the scaled and saturated results.
    always_comb
    begin
        if (term_reg == 2'd3)
            word_off = 4'(lbvs_pkg::TRANS_BASE) + {2'b0, comp_reg};
        else
            word_off = {1'b0, term_reg, 1'b0} + {2'b0, term_reg} + {2'b0, comp_reg};
        rd_addr = cur_reg.addr + lbvs_pkg::ADDR_W'(word_off);
        case (term_reg)
            2'd0:    opnd = cur_reg.vx;
            2'd1:    opnd = cur_reg.vy;
            default: opnd = cur_reg.vz;
        endcase
        prod_sh = prod_reg >>> lbvs_pkg::FRAC_BITS;
        sum_sat = lbvs_pkg::sat_word(64'(sum_reg));
        w_term  = lbvs_pkg::sat_word(prod_sh);
        acc_sum = lbvs_pkg::sat_word(64'(acc_reg[comp_reg]) + 64'(w_term));
    end

    // Bone store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bone_mem[q_item.addr] <= q_item.vx;
        rdata_reg <= bone_mem[rd_addr];
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbvs_pkg::ST_IDLE;
            comp_reg      <= '0;
            term_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lbvs_pkg::ST_IDLE)
            begin
                comp_reg <= '0;
                term_reg <= '0;
            end
            else if (state_reg == lbvs_pkg::ST_ACC)
                term_reg <= term_reg + 1'b1;
            else if (state_reg == lbvs_pkg::ST_WACC || state_reg == lbvs_pkg::ST_NORM)
            begin
                comp_reg <= comp_reg + 1'b1;
                term_reg <= '0;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Accumulated position and held normal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
                hn_reg[i]  <= '0;
            end
        end
        else
        begin
            if (state_reg == lbvs_pkg::ST_IDLE && q_valid
                && q_item.cmd == lbvs_pkg::CMD_VERTEX)
            begin
                for (int i = 0; i < 3; i++)
                    acc_reg[i] <= '0;
                if (!q_item.ok)
                begin
                    hn_reg[0] <= q_item.vx;
                    hn_reg[1] <= q_item.vy;
                    hn_reg[2] <= q_item.vz;
                end
            end
            if (state_reg == lbvs_pkg::ST_NORM)
                hn_reg[comp_reg] <= sum_sat;
            if (state_reg == lbvs_pkg::ST_WACC)
                acc_reg[comp_reg] <= acc_sum;
            if (out_load)
            begin
                for (int i = 0; i < 3; i++)
                    acc_reg[i] <= '0;
            end
        end
    end

    // Datapath registers: item, dot-product sum, shared multiplier, result.
    always_ff @(posedge clk)
    begin
        if (state_reg == lbvs_pkg::ST_IDLE)
        begin
            if (q_valid)
                cur_reg <= q_item;
            sum_reg <= '0;
        end
        if (state_reg == lbvs_pkg::ST_MUL)
            prod_reg <= opnd * rdata_reg;
        if (state_reg == lbvs_pkg::ST_WMUL)
            prod_reg <= sum_sat * cur_reg.wt;
        if (state_reg == lbvs_pkg::ST_ACC)
        begin
            if (term_reg == 2'd3)
                sum_reg <= sum_reg + {{(lbvs_pkg::SUM_W - 32){rdata_reg[31]}}, rdata_reg};
            else
                sum_reg <= sum_reg + $signed(prod_sh[lbvs_pkg::SUM_W-1:0]);
        end
        if (state_reg == lbvs_pkg::ST_WACC || state_reg == lbvs_pkg::ST_NORM)
            sum_reg <= '0;
        if (out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= acc_reg[i];
                norm_reg[i] <= hn_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign norm_x    = norm_reg[0];
    assign norm_y    = norm_reg[1];
    assign norm_z    = norm_reg[2];

endmodule

`default_nettype wire

[rtl/lbvs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbvs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] pos_x,
    input wire logic [31:0] norm_z
);

    // A stalled result stays valid and holds its pos_x and norm_z.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(norm_z))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result pending in reset");

    // Reset leaves the queue empty and open.
    assert property (@(posedge clk) !rst_n |-> in_ready)
        else $error("input not ready in reset");

endmodule

bind linear_blend_vertex_skinner lbvs_checker u_lbvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .norm_z    (norm_z)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef logic signed [31:0] word_t;

    // Expected output of one vertex.
    typedef struct {
        word_t px;
        word_t py;
        word_t pz;
        word_t nx;
        word_t ny;
        word_t nz;
    } skin_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  bone;
    logic [3:0]  elem;
    word_t       vec_x;
    word_t       vec_y;
    word_t       vec_z;
    word_t       blend;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    word_t       pos_x;
    word_t       pos_y;
    word_t       pos_z;
    word_t       norm_x;
    word_t       norm_y;
    word_t       norm_z;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    // Shadow state of the skinner.
    word_t        bone_mem [lbvs_pkg::MAX_BONES*lbvs_pkg::WORDS_PER_BONE];
    bit           bone_set [lbvs_pkg::MAX_BONES*lbvs_pkg::WORDS_PER_BONE];
    word_t        acc_pos [3];
    word_t        normal_hold [3];
    int unsigned  valid_bones;
    skin_result_t pending_vertices [$];

    int  errors;
    bit  no_idle;
    int  out_stall;

    linear_blend_vertex_skinner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .bone      (bone),
        .elem      (elem),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .blend     (blend),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Truncating fixed-point multiply.
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> lbvs_pkg::FRAC_BITS;
    endfunction

    function automatic word_t clamp32(input logic signed [63:0] x);
        word_t r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic bit bone_ok(input logic [7:0] b);
        return (b < valid_bones) && (b < lbvs_pkg::MAX_BONES);
    endfunction

    // Rotates a vector by a bone, with the translation added for positions.
    task automatic rotate_by_bone(input logic [7:0] b, input word_t vx, input word_t vy,
                                  input word_t vz, input bit with_t,
                                  output word_t rx, output word_t ry, output word_t rz);
        logic signed [63:0] s;
        word_t              r [3];
        int                 base;
        base = b * lbvs_pkg::WORDS_PER_BONE;
        for (int c = 0; c < 3; c++)
        begin
            s = qmul(vx, bone_mem[base + c]) + qmul(vy, bone_mem[base + 3 + c])
                + qmul(vz, bone_mem[base + 6 + c]);
            if (with_t)
                s = s + bone_mem[base + lbvs_pkg::TRANS_BASE + c];
            r[c] = clamp32(s);
        end
        rx = r[0];
        ry = r[1];
        rz = r[2];
    endtask

    // Updates the shadow state for one accepted item.
    task automatic predict_skin(input logic [1:0] f, input logic [7:0] b, input logic [3:0] e,
                                input word_t vx, input word_t vy, input word_t vz,
                                input word_t wt, input logic lst);
        word_t        r [3];
        word_t        term;
        skin_result_t res;
        if (f == lbvs_pkg::FUNC_LOAD)
        begin
            if (b < lbvs_pkg::MAX_BONES && e < lbvs_pkg::WORDS_PER_BONE)
            begin
                bone_mem[b*lbvs_pkg::WORDS_PER_BONE + e] = vx;
                bone_set[b*lbvs_pkg::WORDS_PER_BONE + e] = 1'b1;
            end
            return;
        end
        if (f == lbvs_pkg::FUNC_NONE)
            return;
        if (f == lbvs_pkg::FUNC_VERTEX)
        begin
            for (int c = 0; c < 3; c++)
                acc_pos[c] = '0;
            if (bone_ok(b))
                rotate_by_bone(b, vx, vy, vz, 1'b0, normal_hold[0], normal_hold[1],
                               normal_hold[2]);
            else
            begin
                normal_hold[0] = vx;
                normal_hold[1] = vy;
                normal_hold[2] = vz;
            end
        end
        else if (bone_ok(b))
        begin
            rotate_by_bone(b, vx, vy, vz, 1'b1, r[0], r[1], r[2]);
            for (int c = 0; c < 3; c++)
            begin
                term = clamp32(qmul(r[c], wt));
                acc_pos[c] = clamp32(64'(acc_pos[c]) + 64'(term));
            end
        end
        if (!lst)
            return;
        res.px = acc_pos[0];
        res.py = acc_pos[1];
        res.pz = acc_pos[2];
        res.nx = normal_hold[0];
        res.ny = normal_hold[1];
        res.nz = normal_hold[2];
        pending_vertices.push_back(res);
        for (int c = 0; c < 3; c++)
            acc_pos[c] = '0;
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // Sends one item and waits until it is accepted.
    task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic [3:0] e,
                             input word_t vx, input word_t vy, input word_t vz,
                             input word_t wt, input logic lst);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        func     <= f;
        bone     <= b;
        elem     <= e;
        vec_x    <= vx;
        vec_y    <= vy;
        vec_z    <= vz;
        blend    <= wt;
        last     <= lst;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_skin(f, b, e, vx, vy, vz, wt, lst);
    endtask

    // Waits until every expected vertex has come and the block has gone quiet.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_bone_count(input logic [7:0] value);
        drain_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        valid_bones = value;
    endtask

    // Random Q16.16 value: mostly near unity, sometimes extreme or raw.
    function automatic word_t rand_fixed();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        endcase
    endfunction

    function automatic bit bone_loaded(input int b);
        for (int e = 0; e < lbvs_pkg::WORDS_PER_BONE; e++)
            if (!bone_set[b*lbvs_pkg::WORDS_PER_BONE + e])
                return 1'b0;
        return 1'b1;
    endfunction

    // Picks a bone that is either fully loaded or out of range.
    function automatic logic [7:0] pick_bone();
        int b;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(valid_bones, 255));
        for (int t = 0; t < 8; t++)
        begin
            b = $urandom_range(0, valid_bones - 1);
            if (bone_loaded(b))
                return 8'(b);
        end
        return 8'd0;
    endfunction

    task automatic load_bone(input logic [7:0] b, input bit identity);
        word_t v;
        for (int e = 0; e < lbvs_pkg::WORDS_PER_BONE; e++)
        begin
            if (identity)
                v = (e == 0 || e == 4 || e == 8) ? 32'sh10000 : 32'sh0;
            else
                v = rand_fixed();
            send_item(lbvs_pkg::FUNC_LOAD, b, 4'(e), v, $urandom, $urandom, $urandom,
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Fills a few bones, among them the highest one, and tries ignored loads.
    task automatic test_bone_loads();
        load_bone(8'd0, 1'b1);
        for (int b = 1; b < 8; b++)
            load_bone(8'(b), 1'b0);
        load_bone(8'(lbvs_pkg::MAX_BONES - 1), 1'b0);
        send_item(lbvs_pkg::FUNC_LOAD, 8'd200, 4'd3, $urandom, 0, 0, 0, 1'b1);
        send_item(lbvs_pkg::FUNC_LOAD, 8'd2, 4'd15, $urandom, 0, 0, 0, 1'b0);
        send_item(lbvs_pkg::FUNC_LOAD, 8'd255, 4'd12, $urandom, 0, 0, 0, 1'b1);
    endtask

    // Directed vertices covering every operation and corner case.
    task automatic test_directed_vertices();
        // Vertex without weights gives a zero position at once.
        send_item(lbvs_pkg::FUNC_VERTEX, 8'd0, 4'd0, 32'sh10000, 32'sh20000, -32'sh10000, 0,
                  1'b1);
        // Identity bone with two weights.
        send_item(lbvs_pkg::FUNC_VERTEX, 8'd0, 4'd0, 32'sh8000, 32'sh8000, 32'sh0, 0, 1'b0);
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'd0, 4'd0, 32'sh30000, -32'sh20000, 32'sh1,
                  32'sh8000, 1'b0);
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'd1, 4'd0, 32'sh10000, 32'sh10000, 32'sh10000,
                  32'sh8000, 1'b1);
        // Out-of-range bone on the vertex passes the normal through.
        send_item(lbvs_pkg::FUNC_VERTEX, 8'd200, 4'd0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  -32'sh1, 0, 1'b0);
        // Out-of-range weight adds nothing but still closes the vertex.
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'd255, 4'd0, 32'sh10000, 0, 0, 32'sh10000, 1'b1);
        // Extreme values drive every saturation path.
        send_item(lbvs_pkg::FUNC_VERTEX, 8'd7, 4'd15, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'd7, 4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'(lbvs_pkg::MAX_BONES - 1), 4'd0, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        // Unused function code and a load marked last give nothing.
        send_item(lbvs_pkg::FUNC_NONE, 8'd1, 4'd5, $urandom, $urandom, $urandom, $urandom,
                  1'b1);
        send_item(lbvs_pkg::FUNC_LOAD, 8'd0, 4'd9, 32'sh0, 0, 0, 0, 1'b1);
        // Weights with no vertex before them start from a zero position and report the held normal.
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'd3, 4'd0, 32'sh20000, 32'sh10000, -32'sh30000,
                  -32'sh10000, 1'b0);
        send_item(lbvs_pkg::FUNC_WEIGHT, 8'd4, 4'd0, -32'sh1, 32'sh1, 32'sh0, 32'sh18000,
                  1'b1);
    endtask

    // One random vertex: a begin item and up to four weights.
    task automatic send_random_vertex();
        int nw;
        nw = $urandom_range(0, 4);
        send_item(lbvs_pkg::FUNC_VERTEX, pick_bone(), 4'($urandom), rand_fixed(), rand_fixed(),
                  rand_fixed(), $urandom, nw == 0);
        for (int i = 0; i < nw; i++)
            send_item(lbvs_pkg::FUNC_WEIGHT, pick_bone(), 4'($urandom), rand_fixed(),
                      rand_fixed(), rand_fixed(), rand_fixed(), i == nw - 1);
    endtask

    task automatic send_noise_item();
        case ($urandom_range(0, 3))
            0: send_item(lbvs_pkg::FUNC_LOAD, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)), rand_fixed(), $urandom, $urandom,
                         $urandom, 1'($urandom_range(0, 1)));
            1: send_item(lbvs_pkg::FUNC_NONE, 8'($urandom), 4'($urandom), $urandom, $urandom,
                         $urandom, $urandom, 1'($urandom_range(0, 1)));
            default: send_item(lbvs_pkg::FUNC_WEIGHT, pick_bone(), 4'($urandom), rand_fixed(),
                               rand_fixed(), rand_fixed(), rand_fixed(),
                               1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic run_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent % 60 < 15)
                no_idle = 1'b1;
            else
                no_idle = 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                send_noise_item();
                sent += 1;
            end
            else
            begin
                send_random_vertex();
                sent += 3;
            end
        end
        no_idle = 1'b0;
    endtask

    // Runs vertices under bone counts of 1 and 5, then restores the full count.
    task automatic test_bone_counts();
        write_bone_count(8'd1);
        test_directed_vertices();
        run_random(60);
        write_bone_count(8'd5);
        run_random(80);
        write_bone_count(8'(lbvs_pkg::MAX_BONES));
    endtask

    task automatic test_random_mesh();
        run_random(420);
    endtask

    // Checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        skin_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("unexpected result pos_x", pos_x, '0);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (pos_x !== want.px) report_mismatch("pos_x", pos_x, want.px);
                if (pos_y !== want.py) report_mismatch("pos_y", pos_y, want.py);
                if (pos_z !== want.pz) report_mismatch("pos_z", pos_z, want.pz);
                if (norm_x !== want.nx) report_mismatch("norm_x", norm_x, want.nx);
                if (norm_y !== want.ny) report_mismatch("norm_y", norm_y, want.ny);
                if (norm_z !== want.nz) report_mismatch("norm_z", norm_z, want.nz);
            end
            out_stall = draw_gap();
        end
    end

    // Receiver back-pressure, drawn after each result.
    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall = out_stall - 1;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        errors      = 0;
        no_idle     = 1'b0;
        out_stall   = 0;
        valid_bones = lbvs_pkg::MAX_BONES;
        for (int i = 0; i < 3; i++)
        begin
            acc_pos[i]     = '0;
            normal_hold[i] = '0;
        end
        for (int i = 0; i < lbvs_pkg::MAX_BONES*lbvs_pkg::WORDS_PER_BONE; i++)
            bone_set[i] = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = '0;
        bone      = '0;
        elem      = '0;
        vec_x     = '0;
        vec_y     = '0;
        vec_z     = '0;
        blend     = '0;
        last      = 1'b0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_bone_loads();
        test_directed_vertices();
        test_bone_counts();
        test_random_mesh();
        drain_block();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
